FILE: sv/sfprng_pkg.sv
// shared types, constants and the round function for the small fast prng block
// no dependencies
package sfprng_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned ROT_B     = 27;
  localparam int unsigned ROT_C     = 17;

  localparam logic [WORD_W-1:0] SEED_CONST = 32'hf1ea5eed;

  // register index of the seed register (bit 2 of the byte address)
  localparam logic REG_SEED = 1'b0;

  typedef enum logic [1:0] {
    ST_WARM,
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic advance;   // one generator round, no capture
    logic capture;   // advance and latch the item
    logic div_step;  // one restoring divide step
    logic out_load;  // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic seed_wr;   // seed register written this cycle
    logic need_div;  // incoming item needs the modulo
    logic out_busy;  // output register holds a beat not taken
  } sts_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
  } words_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                              input int unsigned k);
    rotl = (x << k) | (x >> (WORD_W - k));
  endfunction

  // one generator round; the new d is the output word
  function automatic words_t jsf_round(input words_t w);
    logic [WORD_W-1:0] e;
    words_t n;
    e   = w.a - rotl(w.b, ROT_B);
    n.a = w.b ^ rotl(w.c, ROT_C);
    n.b = w.c + w.d;
    n.c = w.d + e;
    n.d = e + n.a;
    jsf_round = n;
  endfunction

endpackage

FILE: sv/small_fast_prng_with_range_top.sv
// top level of the small fast prng with range reduction
// depends on sfprng_pkg, sfprng_ctrl, sfprng_dp
//
//   channel | dir  | handshake            | payload
//   in_     | in   | in_tvalid/in_tready  | tdata: range_low, range_high; tuser: mode
//   out_    | out  | out_tvalid/out_tready| tdata: value
//   cfg_    | in   | apb write/read       | seed_value at byte address 0
//
// raw mode or a full-word span: each item takes a capture round, then an output load
// ranged mode: capture, the 32-step restoring divider, then output load; one item at a time
// after reset and after each seed write, in_tready stays low while the warm-up
// rounds run
// a result not taken holds the block in its finish state until out_tready
module small_fast_prng_with_range_top
  import sfprng_pkg::*;
#(
  parameter int unsigned WARMUP_ROUNDS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // [31:0] range_low, [63:32] range_high
  input  logic        in_tuser,    // [0] mode
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] value
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cmd_t cmd;
  sts_t sts;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  sfprng_ctrl #(
    .WARMUP_ROUNDS (WARMUP_ROUNDS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sfprng_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_wr),
    .cfg_idx    (cfg_paddr[2]),
    .cfg_wdata  (cfg_pwdata),
    .cfg_rdata  (cfg_prdata),
    .mode       (in_tuser),
    .range_low  (in_tdata[31:0]),
    .range_high (in_tdata[63:32]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

  // one item at a time: no second beat right after a capture
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item accepted during processing");

  // a seed write always starts warm-up
  a_seed_warm: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_paddr[2] == REG_SEED) |=> !in_tready)
    else $error("item accepted right after reseed");

  // ranged item never produces a result in the next cycle
  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser && sts.need_div && !out_tvalid)
      |=> !out_tvalid)
    else $error("ranged result too early");

endmodule

FILE: sv/sfprng_ctrl.sv
// controller state machine: warm-up sequencing, item capture, divide steps, output load
// depends on sfprng_pkg
module sfprng_ctrl
  import sfprng_pkg::*;
#(
  parameter int unsigned WARMUP_ROUNDS = 20
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int unsigned CNT_MAX =
    (WARMUP_ROUNDS > DIV_STEPS) ? WARMUP_ROUNDS : DIV_STEPS;
  localparam int unsigned CNT_W = $clog2(CNT_MAX + 1);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // state and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WARM;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // a seed write in the same cycle takes priority over a new beat
  assign in_tready = (state_r == ST_IDLE) && !sts.seed_wr;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    if (sts.seed_wr) begin
      state_nxt = ST_WARM;
      cnt_nxt   = '0;
    end else begin
      case (state_r)
        ST_WARM: begin
          if (cnt_r == CNT_W'(WARMUP_ROUNDS)) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
            cnt_nxt     = cnt_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_tvalid) begin
            cmd.capture = 1'b1;
            cnt_nxt     = '0;
            state_nxt   = sts.need_div ? ST_DIV : ST_FINISH;
          end
        end
        ST_DIV: begin
          cmd.div_step = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            state_nxt = ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!sts.out_busy) begin
            cmd.out_load = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
        default: begin
          state_nxt = ST_WARM;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

  // divide count stays within its step range
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> cnt_r < CNT_W'(DIV_STEPS))
    else $error("divide counter out of range");

  // warm-up count never runs past the round count
  a_warm_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WARM |-> cnt_r <= CNT_W'(WARMUP_ROUNDS))
    else $error("warm-up counter out of range");

  // at most one datapath command per cycle
  a_cmd_one: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.advance, cmd.capture, cmd.div_step, cmd.out_load}))
    else $error("conflicting datapath commands");

  // a finished divide always lands in the finish state
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r == CNT_W'(DIV_STEPS - 1) && !sts.seed_wr)
      |=> state_r == ST_FINISH)
    else $error("divide did not end in finish");

endmodule

FILE: sv/sfprng_dp.sv
// datapath: generator words, seed register, restoring divider, output register
// depends on sfprng_pkg
module sfprng_dp
  import sfprng_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_wr,
  input  logic              cfg_idx,
  input  logic [WORD_W-1:0] cfg_wdata,
  output logic [WORD_W-1:0] cfg_rdata,
  // item fields
  input  logic              mode,
  input  logic [WORD_W-1:0] range_low,
  input  logic [WORD_W-1:0] range_high,
  // result
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [WORD_W-1:0] out_value,
  // controller link
  input  cmd_t              cmd,
  output sts_t              sts
);

  logic [WORD_W-1:0] seed_r;
  words_t            words_r, words_nxt, words_adv;
  logic [WORD_W-1:0] span_in;
  logic [WORD_W-1:0] span_r, lo_r, rem_r, q_r;
  logic              div_r;
  logic [WORD_W:0]   rem_sh, span_ext;
  logic              q_bit;
  logic [WORD_W-1:0] rem_nxt;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_data_r;
  logic              seed_wr;

  assign seed_wr   = cfg_wr && (cfg_idx == REG_SEED);
  assign cfg_rdata = (cfg_idx == REG_SEED) ? seed_r : '0;

  // seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (seed_wr) begin
      seed_r <= cfg_wdata;
    end
  end

  // generator words: reseed on write, one round per advance or capture
  assign words_adv = jsf_round(words_r);

  always_comb begin
    words_nxt = words_r;
    if (seed_wr) begin
      words_nxt.a = SEED_CONST;
      words_nxt.b = cfg_wdata;
      words_nxt.c = cfg_wdata;
      words_nxt.d = cfg_wdata;
    end else if (cmd.advance || cmd.capture) begin
      words_nxt = words_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r.a <= SEED_CONST;
      words_r.b <= '0;
      words_r.c <= '0;
      words_r.d <= '0;
    end else begin
      words_r <= words_nxt;
    end
  end

  // span of the incoming item; zero means the full word range
  assign span_in = range_high - range_low + 1'b1;

  // restoring divide step; quotient bits shift into q_r, only the remainder is used
  assign rem_sh   = {rem_r, q_r[WORD_W-1]};
  assign span_ext = {1'b0, span_r};
  assign q_bit    = (rem_sh >= span_ext);
  assign rem_nxt  = q_bit ? WORD_W'(rem_sh - span_ext) : rem_sh[WORD_W-1:0];

  // item capture and divider registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_r    <= words_adv.d;
      rem_r  <= '0;
      span_r <= span_in;
      lo_r   <= mode ? range_low : '0;
      div_r  <= mode && (span_in != '0);
    end else if (cmd.div_step) begin
      q_r   <= {q_r[WORD_W-2:0], q_bit};
      rem_r <= rem_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= (div_r ? rem_r : q_r) + lo_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_value  = out_data_r;

  assign sts.seed_wr  = seed_wr;
  assign sts.need_div = mode && (span_in != '0);
  assign sts.out_busy = out_valid_r && !out_tready;

endmodule
